>>> rtl/polar_convert_spiral_classify_assert.svh
// Assertion macros used by the top level of the polar converter.
`ifndef POLAR_CONVERT_SPIRAL_CLASSIFY_ASSERT_SVH
`define POLAR_CONVERT_SPIRAL_CLASSIFY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCSC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pcsc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PCSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pcsc assertion failed");

`endif

>>> rtl/pcsc_pkg.sv
`timescale 1ns / 1ps
package pcsc_pkg;

	localparam int COORD_W = 16;
	localparam int WORK_SHIFT = 14;
	// Working width: the pre-rotated value times 2^14 plus CORDIC growth fits in 33 bits.
	localparam int WORK_W = 34;
	localparam int ATAN_ENTRIES = 24;
	localparam int GAIN_W = 30;
	localparam int PROD_W = WORK_W - 1 + GAIN_W;
	localparam int RAD_SHIFT = 44;
	localparam int RQ_W = PROD_W - RAD_SHIFT;
	localparam int DIFF_W = 20;

	localparam logic [31:0] HALF_TURN = 32'h8000_0000;
	localparam logic [GAIN_W-1:0] INV_GAIN = 30'd652032874;
	localparam logic [PROD_W-1:0] RAD_ROUND = PROD_W'(64'd1 << (RAD_SHIFT - 1));
	localparam logic [RQ_W-1:0] RAD_MAX = RQ_W'(65535);

	// Band limits for the difference 4*radius - angle, one band per turn offset.
	localparam logic signed [DIFF_W-1:0] BAND_LO_M1 = -20'sd65536;
	localparam logic signed [DIFF_W-1:0] BAND_HI_M1 = -20'sd32768;
	localparam logic signed [DIFF_W-1:0] BAND_LO_0 = 20'sd0;
	localparam logic signed [DIFF_W-1:0] BAND_HI_0 = 20'sd32768;
	localparam logic signed [DIFF_W-1:0] BAND_LO_P1 = 20'sd65536;
	localparam logic signed [DIFF_W-1:0] BAND_HI_P1 = 20'sd98304;

	// atan(2^-i) in units of 2^-32 turn.
	localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81
	};

	typedef struct packed {
		logic signed [WORK_W-1:0] x;
		logic signed [WORK_W-1:0] y;
		logic [31:0] z;
		logic origin;
	} cell_t;

	typedef struct packed {
		logic [COORD_W-1:0] radius;
		logic [COORD_W-1:0] angle;
		logic spiral_class;
	} result_t;

endpackage

>>> rtl/pcsc_in_if.sv
`timescale 1ns / 1ps
interface pcsc_in_if import pcsc_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [COORD_W-1:0] x_coord;
	logic signed [COORD_W-1:0] y_coord;

	modport source (output valid, output x_coord, output y_coord, input ready);
	modport sink (input valid, input x_coord, input y_coord, output ready);
endinterface

>>> rtl/pcsc_out_if.sv
`timescale 1ns / 1ps
interface pcsc_out_if import pcsc_pkg::*; ();
	logic valid;
	logic ready;
	logic [COORD_W-1:0] radius;
	logic [COORD_W-1:0] angle;
	logic spiral_class;

	modport source (output valid, output radius, output angle, output spiral_class,
		input ready);
	modport sink (input valid, input radius, input angle, input spiral_class,
		output ready);
endinterface

>>> rtl/pcsc_cell.sv
`timescale 1ns / 1ps
module pcsc_cell import pcsc_pkg::*; #(
	parameter int STAGE = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  valid,
	input  cell_t data,
	output logic  valid_q,
	output cell_t data_q
);

	cell_t nxt;

	// One vectoring micro-rotation: drive y toward zero.
	always_comb begin
		nxt = data;
		if (!data.y[WORK_W-1]) begin
			nxt.x = data.x + (data.y >>> STAGE);
			nxt.y = data.y - (data.x >>> STAGE);
			nxt.z = data.z + ATAN_TURNS[STAGE];
		end else begin
			nxt.x = data.x - (data.y >>> STAGE);
			nxt.y = data.y + (data.x >>> STAGE);
			nxt.z = data.z - ATAN_TURNS[STAGE];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

endmodule

>>> rtl/pcsc_post.sv
`timescale 1ns / 1ps
module pcsc_post import pcsc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    valid,
	input  cell_t   data,
	output logic    valid_q,
	output result_t res_s3
);

	logic v_s1, v_s2;
	logic [WORK_W-2:0] x_pos;
	logic [PROD_W-1:0] prod_s1;
	logic [31:0] z_s1;
	logic origin_s1;
	logic [PROD_W-1:0] sum;
	logic [RQ_W-1:0] rq;
	logic [COORD_W-1:0] rad_s2, ang_s2;
	logic signed [DIFF_W-1:0] diff;
	logic in_band;

	// A negative final x is clamped to zero before the gain correction.
	assign x_pos = data.x[WORK_W-1] ? '0 : data.x[WORK_W-2:0];

	assign sum = prod_s1 + RAD_ROUND;
	assign rq = sum[PROD_W-1:RAD_SHIFT];

	assign diff = $signed({2'b00, rad_s2, 2'b00}) - $signed({4'b0000, ang_s2});
	assign in_band = (diff >= BAND_LO_M1 && diff <= BAND_HI_M1) ||
		(diff >= BAND_LO_0 && diff <= BAND_HI_0) ||
		(diff >= BAND_LO_P1 && diff <= BAND_HI_P1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= valid;
			v_s2 <= v_s1;
			valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= {{GAIN_W{1'b0}}, x_pos} * {{(WORK_W - 1){1'b0}}, INV_GAIN};
			z_s1 <= data.z;
			origin_s1 <= data.origin;
			if (origin_s1) begin
				rad_s2 <= '0;
				ang_s2 <= '0;
			end else begin
				rad_s2 <= (rq > RAD_MAX) ? RAD_MAX[COORD_W-1:0] : rq[COORD_W-1:0];
				ang_s2 <= z_s1[31:16] + {{(COORD_W - 1){1'b0}}, z_s1[15]};
			end
			res_s3.radius <= rad_s2;
			res_s3.angle <= ang_s2;
			res_s3.spiral_class <= !in_band;
		end
	end

endmodule

>>> rtl/polar_convert_spiral_classify.sv
`timescale 1ns / 1ps
// Cartesian-to-polar converter with a two-arm spiral classifier.
// Channel point (sink) carries x_coord and y_coord in signed Q1.15; channel
// result (source) carries radius (unsigned Q1.15), angle (65536 codes per
// turn, zero on the positive x axis) and spiral_class. A transfer happens at
// a rising clock edge with valid and ready both high.
// Throughput is one point per cycle while point.ready is high: the row of
// CORDIC_STAGES rotation cells and three post stages (gain multiply, rounding,
// band compare) all advance together. A point passes the rotation cells, the
// post stages and then the output register before result.valid rises.
// The output register is backed by a one-entry skid register. While the
// receiver stalls, the pipeline keeps taking points until a second finished
// result waits; then point.ready drops, straight from a register, and the
// whole row holds until the receiver takes a result.
// Reset clears all valid flags and empties the output and skid registers;
// the block is ready for a point in the first cycle after reset.
module polar_convert_spiral_classify import pcsc_pkg::*; #(
	parameter int CORDIC_STAGES = 16
) (
	input logic clk,
	input logic arst_n,
	pcsc_in_if.sink point,
	pcsc_out_if.source result
);

`include "polar_convert_spiral_classify_assert.svh"

	logic en;
	logic signed [WORK_W-1:0] xs, ys;
	cell_t head;
	cell_t chain_d [CORDIC_STAGES+1];
	logic chain_v [CORDIC_STAGES+1];
	logic post_v;
	result_t post_r;
	logic out_valid_q, skid_valid_q;
	result_t out_q, skid_q;
	logic out_take, load_out, out_from_skid, load_skid;

	// The pipeline moves whenever the skid register is empty.
	assign en = !skid_valid_q;
	assign point.ready = en;

	// Pre-rotation: fold the left half-plane over by half a turn, then scale
	// into the working format.
	always_comb begin
		xs = WORK_W'(point.x_coord);
		ys = WORK_W'(point.y_coord);
		head.z = '0;
		if (point.x_coord[COORD_W-1]) begin
			xs = -xs;
			ys = -ys;
			head.z = HALF_TURN;
		end
		head.x = xs <<< WORK_SHIFT;
		head.y = ys <<< WORK_SHIFT;
		head.origin = (point.x_coord == '0) && (point.y_coord == '0);
	end

	assign chain_d[0] = head;
	assign chain_v[0] = point.valid;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		pcsc_cell #(
			.STAGE (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid   (chain_v[i]),
			.data    (chain_d[i]),
			.valid_q (chain_v[i+1]),
			.data_q  (chain_d[i+1])
		);
	end

	pcsc_post u_post (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid   (chain_v[CORDIC_STAGES]),
		.data    (chain_d[CORDIC_STAGES]),
		.valid_q (post_v),
		.res_s3  (post_r)
	);

	// Output register and skid register. A finished result leaves the post
	// stage exactly when en is high; it lands in the output register when that
	// is free or being emptied, and in the skid register otherwise.
	assign out_take = out_valid_q && result.ready;
	assign out_from_skid = out_take && skid_valid_q;
	assign load_out = post_v && en && (!out_valid_q || out_take);
	assign load_skid = post_v && en && out_valid_q && !out_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_from_skid || load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			if (out_from_skid) begin
				skid_valid_q <= 1'b0;
			end else if (load_skid) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_from_skid) begin
			out_q <= skid_q;
		end else if (load_out) begin
			out_q <= post_r;
		end
		if (load_skid) begin
			skid_q <= post_r;
		end
	end

	assign result.valid = out_valid_q;
	assign result.radius = out_q.radius;
	assign result.angle = out_q.angle;
	assign result.spiral_class = out_q.spiral_class;

	// The skid register only fills behind a waiting output result.
	`PCSC_ASSERT_SAME(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q)
	// A stalled output with a result arriving must capture it in the skid register.
	`PCSC_ASSERT_NEXT(a_skid_capture, clk, arst_n,
		out_valid_q && !result.ready && post_v && !skid_valid_q, skid_valid_q)
	// Draining the skid register keeps the output valid and frees the pipeline.
	`PCSC_ASSERT_NEXT(a_skid_drain, clk, arst_n,
		out_valid_q && result.ready && skid_valid_q, out_valid_q && !skid_valid_q)

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the Cartesian-to-polar converter with spiral classifier.
module tb_top;
	import pcsc_pkg::*;

	// Stage count of the instance; the predictor runs the same number of rotations.
	localparam int STAGES = 16;
	// Delay from input transfer to result transfer with the receiver ready.
	localparam int LATENCY = STAGES + 4;
	localparam int ATAN_N = 24;

	// Predictor constants: arctangent table in units of 2^-32 turn and the gain inverse.
	localparam logic [31:0] ATAN_STEP [ATAN_N] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81
	};
	localparam longint unsigned GAIN_INV_Q30 = 64'd652032874;
	localparam logic [31:0] TURN_HALF = 32'h8000_0000;

	// Categories of random points.
	typedef enum int {PT_ANY, PT_SMALL, PT_DISC, PT_AXIS, PT_EDGE} point_kind_t;

	logic clk;
	logic arst_n;

	pcsc_in_if point_if ();
	pcsc_out_if result_if ();

	polar_convert_spiral_classify #(
		.CORDIC_STAGES(STAGES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.point(point_if),
		.result(result_if)
	);

	// Results that accepted points still owe, oldest first.
	result_t polar_due [$];

	int mismatches = 0;
	int points_sent = 0;
	int results_seen = 0;
	int class_zero = 0;
	int class_one = 0;
	// While set, neither side idles.
	bit full_rate = 0;
	int stall_left = 0;

	always #5 clk = ~clk;

	// Work out radius, angle and class of one point the way the block is specified:
	// a vectoring CORDIC on values scaled by 2^14, a 32-bit angle accumulator that
	// wraps modulo one turn, and a rounded gain correction at the end.
	function automatic result_t polar_of(input logic signed [COORD_W-1:0] xi,
		input logic signed [COORD_W-1:0] yi);
		longint px;
		longint py;
		longint dx;
		longint dy;
		longint r4;
		longint lo;
		longint unsigned prod;
		longint unsigned rad;
		longint unsigned ang;
		logic [31:0] acc;
		int i;
		int k;
		result_t res;
		px = xi;
		py = yi;
		acc = '0;
		rad = 0;
		ang = 0;
		// The origin skips the rotations and keeps radius and angle at zero.
		if (px != 0 || py != 0) begin
			// Points left of the y axis are turned by half a turn first.
			if (px < 0) begin
				px = -px;
				py = -py;
				acc = TURN_HALF;
			end
			px = px * 16384;
			py = py * 16384;
			for (i = 0; i < STAGES && i < ATAN_N; i++) begin
				// Arithmetic shifts round toward minus infinity.
				dx = py >>> i;
				dy = px >>> i;
				if (py >= 0) begin
					px = px + dx;
					py = py - dy;
					acc = acc + ATAN_STEP[i];
				end else begin
					px = px - dx;
					py = py + dy;
					acc = acc - ATAN_STEP[i];
				end
			end
			if (px < 0)
				px = 0;
			prod = px;
			prod = prod * GAIN_INV_Q30 + (64'd1 << 43);
			rad = prod >> 44;
			if (rad > 65535)
				rad = 65535;
			// Rounding can carry the angle up to a full turn, which wraps to zero.
			ang = ((64'(acc) + 64'h8000) >> 16) & 64'hFFFF;
		end
		res.radius = rad[COORD_W-1:0];
		res.angle = ang[COORD_W-1:0];
		// Class 0 when 4*radius falls in a band between the arms, for a shift of
		// -1, 0 or +1 turn; the band edges themselves count as inside.
		res.spiral_class = 1'b1;
		r4 = longint'(rad) * 4;
		for (k = -1; k <= 1; k++) begin
			lo = longint'(ang) + k * 65536;
			if (r4 >= lo && r4 <= lo + 32768)
				res.spiral_class = 1'b0;
		end
		return res;
	endfunction

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int idle_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (full_rate || pick < 65)
			return 0;
		else if (pick < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Draw one random coordinate pair of the given category.
	task automatic draw_point(input point_kind_t kind, output logic signed [COORD_W-1:0] xo,
		output logic signed [COORD_W-1:0] yo);
		longint xs;
		longint ys;
		case (kind)
			PT_SMALL: begin
				xo = COORD_W'($urandom_range(0, 512) - 256);
				yo = COORD_W'($urandom_range(0, 512) - 256);
			end
			PT_DISC: begin
				// Rejection loop: keep only points inside the unit circle.
				do begin
					xs = longint'($urandom_range(0, 65534)) - 32767;
					ys = longint'($urandom_range(0, 65534)) - 32767;
				end while (xs * xs + ys * ys > 64'd32767 * 32767);
				xo = COORD_W'(xs);
				yo = COORD_W'(ys);
			end
			PT_AXIS: begin
				xo = COORD_W'($urandom);
				yo = '0;
				case ($urandom_range(0, 3))
					0: yo = xo;
					1: yo = -xo;
					2: begin
						yo = xo;
						xo = '0;
					end
					default: ;
				endcase
			end
			PT_EDGE: begin
				xo = $urandom_range(0, 1) ? 16'sh8000 + COORD_W'($urandom_range(0, 3))
					: 16'sh7FFF - COORD_W'($urandom_range(0, 3));
				yo = COORD_W'($urandom);
				if ($urandom_range(0, 1)) begin
					xs = xo;
					xo = yo;
					yo = COORD_W'(xs);
				end
			end
			default: begin
				xo = COORD_W'($urandom);
				yo = COORD_W'($urandom);
			end
		endcase
	endtask

	// Offer one point and hold it until the block takes it. The expectation is
	// queued at the accepting edge. valid is only lowered when a gap follows, so a
	// back-to-back point never sees valid dropped and raised in one time step.
	task automatic send_point(input logic signed [COORD_W-1:0] xv,
		input logic signed [COORD_W-1:0] yv);
		int gap;
		point_if.valid <= 1'b1;
		point_if.x_coord <= xv;
		point_if.y_coord <= yv;
		do
			@(posedge clk);
		while (!point_if.ready);
		polar_due.push_back(polar_of(xv, yv));
		points_sent++;
		gap = idle_len();
		if (gap > 0) begin
			point_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop offering points until every outstanding result has arrived.
	task automatic wait_all_results();
		point_if.valid <= 1'b0;
		while (polar_due.size() != 0)
			@(posedge clk);
	endtask

	// The origin, every axis direction and points one code away from it.
	task automatic test_origin_and_axes();
		send_point(16'sd0, 16'sd0);
		send_point(16'sd32767, 16'sd0);
		send_point(16'sd0, 16'sd32767);
		send_point(-16'sd32768, 16'sd0);
		send_point(16'sd0, -16'sd32768);
		send_point(16'sd1, 16'sd0);
		send_point(-16'sd1, 16'sd0);
		send_point(16'sd0, 16'sd1);
		send_point(16'sd0, -16'sd1);
		send_point(-16'sd32768, -16'sd1);
		send_point(-16'sd32768, 16'sd1);
	endtask

	// Corners of the coordinate square, the diagonals and the unit circle.
	task automatic test_extremes();
		send_point(-16'sd32768, -16'sd32768);
		send_point(16'sd32767, 16'sd32767);
		send_point(-16'sd32768, 16'sd32767);
		send_point(16'sd32767, -16'sd32768);
		send_point(-16'sd1, -16'sd1);
		send_point(16'sd1, -16'sd1);
		send_point(16'sd23170, 16'sd23170);
		send_point(-16'sd23170, 16'sd23170);
		send_point(-16'sd23170, -16'sd23170);
		send_point(16'sd8192, -16'sd4096);
		send_point(16'sd100, 16'sd3);
	endtask

	// Random points in a mix of categories: most over the whole range or inside
	// the unit circle, some small ones near the inner arms, some on axes,
	// diagonals and the edges of the range.
	task automatic test_random_points(input int count);
		logic signed [COORD_W-1:0] xr;
		logic signed [COORD_W-1:0] yr;
		int pick;
		int n;
		for (n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				draw_point(PT_ANY, xr, yr);
			else if (pick < 65)
				draw_point(PT_DISC, xr, yr);
			else if (pick < 85)
				draw_point(PT_SMALL, xr, yr);
			else if (pick < 93)
				draw_point(PT_AXIS, xr, yr);
			else
				draw_point(PT_EDGE, xr, yr);
			send_point(xr, yr);
		end
	endtask

	// A stretch where points come every cycle and the receiver never stalls.
	task automatic test_full_rate();
		full_rate = 1;
		test_random_points(100);
		full_rate = 0;
	endtask

	// The sender stops until the pipeline has drained, then starts again.
	task automatic test_drain_pause();
		test_random_points(30);
		wait_all_results();
		test_random_points(30);
	endtask

	// The receiver: ready drops for random stalls, but never in a full-rate stretch.
	always @(posedge clk) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
		end else if (stall_left > 0 && !full_rate) begin
			result_if.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			result_if.ready <= 1'b1;
			stall_left <= ($urandom_range(0, 5) == 0) ? idle_len() : 0;
		end
	end

	// Compare each result transfer with the oldest outstanding expectation.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			results_seen++;
			if (result_if.spiral_class === 1'b0)
				class_zero++;
			else
				class_one++;
			if (polar_due.size() == 0) begin
				$error("result transfer with no point outstanding");
				mismatches++;
			end else begin
				want = polar_due.pop_front();
				if (result_if.radius !== want.radius) begin
					$error("radius: expected %0d, got %0d", want.radius, result_if.radius);
					mismatches++;
				end
				if (result_if.angle !== want.angle) begin
					$error("angle: expected %0d, got %0d", want.angle, result_if.angle);
					mismatches++;
				end
				if (result_if.spiral_class !== want.spiral_class) begin
					$error("spiral_class: expected %0d, got %0d", want.spiral_class,
						result_if.spiral_class);
					mismatches++;
				end
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		point_if.valid = 1'b0;
		point_if.x_coord = '0;
		point_if.y_coord = '0;
		result_if.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_origin_and_axes();
		test_extremes();
		test_full_rate();
		test_drain_pause();
		test_random_points(840);

		// Let the pipeline empty, then give stray results time to show up.
		wait_all_results();
		repeat (2 * LATENCY) @(posedge clk);

		$display("Sent %0d points and checked %0d results (class 0: %0d, class 1: %0d).",
			points_sent, results_seen, class_zero, class_one);
		$display("Axes, corners, origin and random points under stalls, full rate and a drain.");
		if (mismatches == 0 && polar_due.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog: the slowest correct run needs well under a tenth of this time.
	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

>>> polar_convert_spiral_classify.f
+incdir+rtl
rtl/pcsc_pkg.sv
rtl/pcsc_in_if.sv
rtl/pcsc_out_if.sv
rtl/pcsc_cell.sv
rtl/pcsc_post.sv
rtl/polar_convert_spiral_classify.sv
tb/sv/tb_top.sv
